### hdl/stp_pkg.sv
// Package for the stepper half-step sequencer: status codes, register indexes,
// reset values, the coil pattern table and the constant divider.
// No dependencies.
`timescale 1ns / 1ps

package stp_pkg;

   localparam int REDUCTION_W = 12;
   localparam int TICKS_W     = 16;
   localparam int CODE_W      = 16;
   localparam int UNIT_W      = 8;
   localparam int CYCLES_W    = REDUCTION_W + CODE_W;
   localparam int COIL_W      = 4;
   localparam int PHASE_W     = 3;

   localparam logic [REDUCTION_W-1:0] REDUCTION_RESET = 12'd512;
   localparam logic [TICKS_W-1:0]     TICKS_RESET     = 16'd20;
   localparam logic [CODE_W-1:0]      ANGLE_MAX       = 16'd360;
   localparam logic [PHASE_W-1:0]     PHASE_LAST      = 3'd7;

   // floor(p / 360) = floor((p >> 3) / 45); the shifted value stays below 2^18
   localparam int DIV_PRE_SHIFT = 3;
   localparam int DIV_IN_W      = 18;
   localparam int DIV_SHIFT     = 24;
   localparam int RECIP_W       = 19;
   localparam logic [RECIP_W-1:0] RECIP_45 = RECIP_W'((2**DIV_SHIFT + 45 - 1) / 45);
   localparam int QUOT_W        = REDUCTION_W;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_UNIT = 2'd1,
      STATUS_RANGE    = 2'd2,
      STATUS_BUSY     = 2'd3
   } status_type;

   typedef enum logic {
      CSR_REDUCTION = 1'b0,
      CSR_TICKS     = 1'b1
   } csr_index_type;

   localparam logic [UNIT_W-1:0] UNIT_ANGLE = 8'd0;
   localparam logic [UNIT_W-1:0] UNIT_TURNS = 8'd1;

   function automatic logic [COIL_W-1:0] coil_pattern(input logic [PHASE_W-1:0] idx);
      logic [COIL_W-1:0] pat;
      case (idx)
         3'd0:    pat = 4'b0001;
         3'd1:    pat = 4'b0011;
         3'd2:    pat = 4'b0010;
         3'd3:    pat = 4'b0110;
         3'd4:    pat = 4'b0100;
         3'd5:    pat = 4'b1100;
         3'd6:    pat = 4'b1000;
         default: pat = 4'b1001;
      endcase
      return pat;
   endfunction

endpackage

### hdl/stepper_half_step_sequencer.sv
// Top level of the stepper half-step sequencer: request register, sequencing
// state, constant divider and result register. Depends on stp_pkg.
`timescale 1ns / 1ps

// Half-step sequencer for a four-coil unipolar stepper.
//
// Request channel (req_): mode 0 is a time tick, mode 1 a motion command with
// direction, unit_select and code. A request is taken when req_valid is high
// and req_stall low. Result channel (rsp_): one result per request, taken
// when rsp_valid is high and rsp_stall low.
// Configuration (csr_): index 0 reduction, index 1 ticks_per_phase; csr_ready
// is always high. Write only while idle.
//
// A request passes through the request register, then the result register.
// Throughput: one request per cycle while rsp_stall is low, set by the single
// state update between the two registers. The request register holds one
// request while a result is stalled, so the channel takes one more request
// while the receiver stalls; req_stall rises only when both registers hold.
// The angle conversion floor(code*reduction/360) finishes in the cycle after
// the command, through a reciprocal multiply; the first coil cycle lasts at
// least eight phase steps, so the count is always in place before it is used.
//
// Reset clears the sequencing state, coils off, both registers empty and the
// configuration back to reduction 512 and 20 ticks per phase.

module stepper_half_step_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_mode,
   input  logic                                req_direction,
   input  logic [stp_pkg::UNIT_W-1:0]          req_unit_select,
   input  logic [stp_pkg::CODE_W-1:0]          req_code,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [stp_pkg::COIL_W-1:0]          rsp_coils,
   output logic                                rsp_busy_res,
   output logic [1:0]                          rsp_status,
   output logic                                rsp_done_res,
   // configuration
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic                                csr_index,
   input  logic [stp_pkg::TICKS_W-1:0]         csr_wdata
);

   // ---------------------------------------------------------------- registers
   logic                               in_valid_ff, in_valid_in;
   logic                               in_mode_ff;
   logic                               in_dir_ff;
   logic [stp_pkg::UNIT_W-1:0]         in_unit_ff;
   logic [stp_pkg::CODE_W-1:0]         in_code_ff;

   logic [stp_pkg::REDUCTION_W-1:0]    reduction_ff, reduction_in;
   logic [stp_pkg::TICKS_W-1:0]        ticks_ff, ticks_in;

   logic [stp_pkg::CYCLES_W-1:0]       remaining_ff, remaining_in;
   logic [stp_pkg::PHASE_W-1:0]        phases_done_ff, phases_done_in;
   logic [stp_pkg::TICKS_W-1:0]        dwell_ff, dwell_in;
   logic                               reverse_ff, reverse_in;
   logic                               active_ff, active_in;
   logic [stp_pkg::COIL_W-1:0]         coil_ff, coil_in;

   logic                               div_pend_ff, div_pend_in;
   logic                               div_turns_ff;
   logic [stp_pkg::CYCLES_W-1:0]       prod_ff;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [stp_pkg::COIL_W-1:0]         rsp_coils_ff;
   logic                               rsp_busy_ff;
   stp_pkg::status_type                rsp_status_ff, status_in;
   logic                               rsp_done_ff, done_in;

   // ---------------------------------------------------------------- handshake
   logic req_accept;
   logic rsp_blocked;
   logic fire;

   assign rsp_blocked = rsp_valid_ff & rsp_stall;
   assign fire        = in_valid_ff & ~rsp_blocked;
   assign req_stall   = in_valid_ff & rsp_blocked;
   assign req_accept  = req_valid & ~req_stall;
   assign csr_ready   = 1'b1;

   // hold a request while its result cannot move on, drop it once it fires
   always_comb begin
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------- config
   always_comb begin
      reduction_in = reduction_ff;
      ticks_in     = ticks_ff;
      if (csr_valid && csr_ready) begin
         case (stp_pkg::csr_index_type'(csr_index))
            stp_pkg::CSR_REDUCTION: reduction_in = csr_wdata[stp_pkg::REDUCTION_W-1:0];
            default:                ticks_in     = csr_wdata;
         endcase
      end
   end

   // ---------------------------------------------------------------- command decode
   logic [stp_pkg::CYCLES_W-1:0] product;
   logic                         is_angle;
   logic                         nonzero;
   logic [stp_pkg::TICKS_W-1:0]  limit;
   logic [stp_pkg::TICKS_W-1:0]  dwell_next;
   logic                         step_due;
   logic [stp_pkg::CYCLES_W-1:0] remaining_dec;

   assign product  = stp_pkg::CYCLES_W'(in_code_ff) * stp_pkg::CYCLES_W'(reduction_ff);
   assign is_angle = (in_unit_ff == stp_pkg::UNIT_ANGLE);
   // an angle yields no cycle below 360 degree-units of product
   assign nonzero  = is_angle ? (product >= stp_pkg::CYCLES_W'(stp_pkg::ANGLE_MAX))
                              : (product != '0);

   // a dwell setting of zero counts as one tick
   assign limit      = (ticks_ff == '0) ? stp_pkg::TICKS_W'(1) : ticks_ff;
   assign dwell_next = dwell_ff + stp_pkg::TICKS_W'(1);
   assign step_due   = (dwell_next >= limit) || (dwell_next == '0);
   assign remaining_dec = remaining_ff - stp_pkg::CYCLES_W'(1);

   // ---------------------------------------------------------------- reciprocal divide
   logic [stp_pkg::DIV_IN_W-1:0]                 div_x;
   logic [stp_pkg::DIV_IN_W+stp_pkg::RECIP_W-1:0] div_mul;
   logic [stp_pkg::QUOT_W-1:0]                   quotient;

   assign div_x    = prod_ff[stp_pkg::DIV_PRE_SHIFT +: stp_pkg::DIV_IN_W];
   assign div_mul  = (stp_pkg::DIV_IN_W+stp_pkg::RECIP_W)'(div_x)
                   * (stp_pkg::DIV_IN_W+stp_pkg::RECIP_W)'(stp_pkg::RECIP_45);
   assign quotient = div_mul[stp_pkg::DIV_SHIFT +: stp_pkg::QUOT_W];

   // ---------------------------------------------------------------- sequencing
   always_comb begin
      remaining_in   = remaining_ff;
      phases_done_in = phases_done_ff;
      dwell_in       = dwell_ff;
      reverse_in     = reverse_ff;
      active_in      = active_ff;
      coil_in        = coil_ff;
      div_pend_in    = 1'b0;
      status_in      = stp_pkg::STATUS_OK;
      done_in        = 1'b0;

      // the cycle count is loaded in the cycle after the command started the motion
      if (div_pend_ff) begin
         remaining_in = div_turns_ff ? prod_ff
                                     : stp_pkg::CYCLES_W'(quotient);
      end

      if (fire) begin
         if (in_mode_ff) begin
            if (active_ff) begin
               status_in = stp_pkg::STATUS_BUSY;
            end else if (in_unit_ff > stp_pkg::UNIT_TURNS) begin
               status_in = stp_pkg::STATUS_BAD_UNIT;
            end else if (is_angle && (in_code_ff > stp_pkg::ANGLE_MAX)) begin
               status_in = stp_pkg::STATUS_RANGE;
            end else if (nonzero) begin
               // start: drive the first pattern of the walk at once
               reverse_in     = in_dir_ff;
               active_in      = 1'b1;
               phases_done_in = '0;
               dwell_in       = '0;
               div_pend_in    = 1'b1;
               coil_in        = stp_pkg::coil_pattern(in_dir_ff ? stp_pkg::PHASE_LAST
                                                                : stp_pkg::PHASE_W'(0));
            end
         end else if (active_ff) begin
            dwell_in = dwell_next;
            if (step_due) begin
               dwell_in = '0;
               if (phases_done_ff == stp_pkg::PHASE_LAST) begin
                  phases_done_in = '0;
                  remaining_in   = remaining_dec;
                  if (remaining_dec == '0) begin
                     // last pattern stays on the coils
                     active_in = 1'b0;
                     done_in   = 1'b1;
                  end else begin
                     coil_in = stp_pkg::coil_pattern(reverse_ff ? stp_pkg::PHASE_LAST
                                                                : stp_pkg::PHASE_W'(0));
                  end
               end else begin
                  phases_done_in = phases_done_ff + stp_pkg::PHASE_W'(1);
                  coil_in = stp_pkg::coil_pattern(reverse_ff
                               ? stp_pkg::PHASE_LAST - phases_done_in
                               : phases_done_in);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         reduction_ff   <= stp_pkg::REDUCTION_RESET;
         ticks_ff       <= stp_pkg::TICKS_RESET;
         remaining_ff   <= '0;
         phases_done_ff <= '0;
         dwell_ff       <= '0;
         reverse_ff     <= 1'b0;
         active_ff      <= 1'b0;
         coil_ff        <= '0;
         div_pend_ff    <= 1'b0;
      end else begin
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         reduction_ff   <= reduction_in;
         ticks_ff       <= ticks_in;
         remaining_ff   <= remaining_in;
         phases_done_ff <= phases_done_in;
         dwell_ff       <= dwell_in;
         reverse_ff     <= reverse_in;
         active_ff      <= active_in;
         coil_ff        <= coil_in;
         div_pend_ff    <= div_pend_in;
      end
   end

   // ---------------------------------------------------------------- payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_mode_ff <= req_mode;
         in_dir_ff  <= req_direction;
         in_unit_ff <= req_unit_select;
         in_code_ff <= req_code;
      end
      if (div_pend_in) begin
         prod_ff      <= product;
         div_turns_ff <= ~is_angle;
      end
      if (fire) begin
         rsp_coils_ff  <= coil_in;
         rsp_busy_ff   <= active_in;
         rsp_status_ff <= status_in;
         rsp_done_ff   <= done_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_coils    = rsp_coils_ff;
   assign rsp_busy_res = rsp_busy_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_done_res = rsp_done_ff;

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the stepper half-step sequencer: directed and random
// requests, a coil sequencing predictor and a result checker in one module.
// Depends on stp_pkg and stepper_half_step_sequencer.
`timescale 1ns / 1ps

module tb_top;

   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_MOVE = 1'b1;

   localparam int DEGREES_PER_TURN = 360;
   localparam int PHASES_PER_CYCLE = 8;
   // nibble i holds the coil pattern of half-step i
   localparam logic [31:0] HALF_STEP_COILS = 32'h98C4_6231;

   localparam int RANDOM_PHASES = 9;
   localparam int PHASE_REQUESTS = 130;
   localparam int MOTION_BUDGET = 200;   // ticks a random motion may last
   localparam int DRAIN_CYCLES = 4;
   localparam int CYCLE_LIMIT = 4_000_000;

   typedef struct packed {
      logic                        mode;
      logic                        direction;
      logic [stp_pkg::UNIT_W-1:0]  unit_select;
      logic [stp_pkg::CODE_W-1:0]  code;
   } request_type;

   typedef struct packed {
      logic [stp_pkg::COIL_W-1:0]  coils;
      logic                        busy;
      logic [1:0]                  status;
      logic                        done;
   } drive_type;

   // clock, reset and every block input known from time zero
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic                        req_mode = MODE_TICK;
   logic                        req_direction = 1'b0;
   logic [stp_pkg::UNIT_W-1:0]  req_unit_select = '0;
   logic [stp_pkg::CODE_W-1:0]  req_code = '0;

   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [stp_pkg::COIL_W-1:0]  rsp_coils;
   logic                        rsp_busy_res;
   logic [1:0]                  rsp_status;
   logic                        rsp_done_res;

   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic                        csr_index = stp_pkg::CSR_REDUCTION;
   logic [stp_pkg::TICKS_W-1:0] csr_wdata = '0;

   stepper_half_step_sequencer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_direction   (req_direction),
      .req_unit_select (req_unit_select),
      .req_code        (req_code),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_coils       (rsp_coils),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_status      (rsp_status),
      .rsp_done_res    (rsp_done_res),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #6 clock = ~clock;

   // Shadow of the sequencer: configuration and motion state
   logic [stp_pkg::REDUCTION_W-1:0] cfg_reduction = stp_pkg::REDUCTION_RESET;
   logic [stp_pkg::TICKS_W-1:0]     cfg_ticks = stp_pkg::TICKS_RESET;
   logic [stp_pkg::CYCLES_W-1:0]    sh_remaining = '0;
   logic [stp_pkg::PHASE_W-1:0]     sh_phases_done = '0;
   logic [stp_pkg::TICKS_W-1:0]     sh_dwell = '0;
   logic                            sh_reverse = 1'b0;
   logic                            sh_active = 1'b0;
   logic [stp_pkg::COIL_W-1:0]      sh_coils = '0;

   request_type request_q[$];       // requests waiting for the driver
   drive_type   drive_forecast[$];  // coil drive and status due, oldest first

   int results_seen = 0;         // results taken by the monitor
   int queued_total = 0;
   int fail_count = 0;
   int requests_taken = 0;
   int motions_started = 0;
   int motions_finished = 0;
   int commands_refused = 0;
   int cycles_run = 0;

   // Eight-phase cycles that a command asks for; exact integer floor for angles
   function automatic logic [stp_pkg::CYCLES_W-1:0] cycle_count(
         input logic [stp_pkg::UNIT_W-1:0] unit,
         input logic [stp_pkg::CODE_W-1:0] code,
         input logic [stp_pkg::REDUCTION_W-1:0] red);
      logic [31:0] product;
      product = 32'(code) * 32'(red);
      if (unit == stp_pkg::UNIT_ANGLE) begin
         product = product / DEGREES_PER_TURN;
      end
      return product[stp_pkg::CYCLES_W-1:0];
   endfunction

   // Drive the pattern of the current step, walking backwards in reverse
   function automatic void load_pattern();
      logic [stp_pkg::PHASE_W-1:0] idx;
      idx = sh_reverse ? stp_pkg::PHASE_LAST - sh_phases_done : sh_phases_done;
      sh_coils = HALF_STEP_COILS[idx*stp_pkg::COIL_W +: stp_pkg::COIL_W];
      sh_dwell = '0;
   endfunction

   // Advance the shadow by one request and return the result it must produce
   function automatic drive_type sequence_step(input request_type rq);
      drive_type                    res;
      logic [stp_pkg::CYCLES_W-1:0] cycles;
      logic [stp_pkg::TICKS_W-1:0]  limit;
      res.status = stp_pkg::STATUS_OK;
      res.done = 1'b0;
      if (rq.mode == MODE_MOVE) begin
         // busy outranks a bad unit, which outranks an angle out of range
         if (sh_active) begin
            res.status = stp_pkg::STATUS_BUSY;
         end else if (rq.unit_select != stp_pkg::UNIT_ANGLE &&
                      rq.unit_select != stp_pkg::UNIT_TURNS) begin
            res.status = stp_pkg::STATUS_BAD_UNIT;
         end else if (rq.unit_select == stp_pkg::UNIT_ANGLE &&
                      rq.code > stp_pkg::ANGLE_MAX) begin
            res.status = stp_pkg::STATUS_RANGE;
         end else begin
            cycles = cycle_count(rq.unit_select, rq.code, cfg_reduction);
            // a zero-length move is accepted but leaves the coils alone
            if (cycles != 0) begin
               sh_remaining = cycles;
               sh_reverse = rq.direction;
               sh_active = 1'b1;
               sh_phases_done = '0;
               load_pattern();
               motions_started++;
            end
         end
      end else if (sh_active) begin
         limit = (cfg_ticks == 0) ? stp_pkg::TICKS_W'(1) : cfg_ticks;
         sh_dwell = sh_dwell + 1'b1;
         if (sh_dwell >= limit || sh_dwell == 0) begin
            sh_dwell = '0;
            if (sh_phases_done == stp_pkg::PHASE_LAST) begin
               sh_phases_done = '0;
               sh_remaining = sh_remaining - 1'b1;
               if (sh_remaining == 0) begin
                  // motion over: the last pattern stays on the coils
                  sh_active = 1'b0;
                  res.done = 1'b1;
               end else begin
                  load_pattern();
               end
            end else begin
               sh_phases_done = sh_phases_done + 1'b1;
               load_pattern();
            end
         end
      end
      res.coils = sh_coils;
      res.busy = sh_active;
      return res;
   endfunction

   function automatic void check_field(input string name, input logic [3:0] want,
                                       input logic [3:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // Request driver: bursts of random length separated by random gaps
   request_type taken;
   request_type upcoming;
   drive_type   predicted;
   int          burst_left = 1;
   int          gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 1;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            taken = '{req_mode, req_direction, req_unit_select, req_code};
            predicted = sequence_step(taken);
            drive_forecast.push_back(predicted);
            requests_taken++;
            if (predicted.status != stp_pkg::STATUS_OK) commands_refused++;
            if (predicted.done) motions_finished++;
         end
         if (req_valid && req_stall) begin
            // hold the stalled request unchanged
         end else if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (request_q.size() != 0) begin
            upcoming = request_q.pop_front();
            req_valid <= 1'b1;
            req_mode <= upcoming.mode;
            req_direction <= upcoming.direction;
            req_unit_select <= upcoming.unit_select;
            req_code <= upcoming.code;
            burst_left--;
            if (burst_left <= 0) begin
               // now and then a long burst, so some stretches run with no gaps
               burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                        : $urandom_range(1, 20);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result monitor: compare against the oldest forecast, stall on its own pattern
   drive_type due;
   int        stall_mode = 0;
   int        stall_span = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (drive_forecast.size() == 0) begin
               $display("%0t ns: result with nothing expected, coils %0h status %0h",
                        $time, rsp_coils, rsp_status);
               fail_count++;
            end else begin
               due = drive_forecast.pop_front();
               check_field("coils", due.coils, rsp_coils);
               check_field("busy_res", 4'(due.busy), 4'(rsp_busy_res));
               check_field("status", 4'(due.status), 4'(rsp_status));
               check_field("done_res", 4'(due.done), 4'(rsp_done_res));
               results_seen++;
            end
         end
         // mode 0 never stalls, mode 3 stalls with probability three in four
         if (stall_span == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_span = $urandom_range(16, 200);
         end else begin
            stall_span--;
         end
         rsp_stall <= ($urandom_range(0, 3) < stall_mode);
      end
   end

   // Give up on a hung run
   always @(posedge clock) begin
      cycles_run <= cycles_run + 1;
      if (cycles_run == CYCLE_LIMIT) begin
         $display("%0t ns: timed out, %0d results still outstanding", $time,
                  queued_total - results_seen);
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic queue_request(input logic mode, input logic dir,
                                input logic [stp_pkg::UNIT_W-1:0] unit,
                                input logic [stp_pkg::CODE_W-1:0] code);
      request_type rq;
      rq = '{mode, dir, unit, code};
      request_q.push_back(rq);
      queued_total++;
   endtask

   // A tick carries random command fields, which the block must ignore
   task automatic queue_tick();
      queue_request(MODE_TICK, 1'($urandom), stp_pkg::UNIT_W'($urandom),
                    stp_pkg::CODE_W'($urandom));
   endtask

   // Commands that start nothing while idle: bad unit, angle out of range, zero length
   task automatic queue_noise();
      case ($urandom_range(0, 3))
         0: queue_tick();
         1: queue_request(MODE_MOVE, 1'($urandom), stp_pkg::UNIT_W'($urandom_range(2, 255)),
                          stp_pkg::CODE_W'($urandom));
         2: queue_request(MODE_MOVE, 1'($urandom), stp_pkg::UNIT_ANGLE,
                          stp_pkg::CODE_W'($urandom_range(361, 65535)));
         default: queue_request(MODE_MOVE, 1'($urandom),
                                stp_pkg::UNIT_W'($urandom_range(0, 1)), '0);
      endcase
   endtask

   // A whole motion: a command, exactly the ticks it needs (with refused commands
   // mixed in while it runs), then a few idle ticks
   task automatic queue_motion(input longint budget);
      logic [stp_pkg::UNIT_W-1:0]   unit;
      logic [stp_pkg::CODE_W-1:0]   code;
      logic [stp_pkg::CYCLES_W-1:0] cycles;
      longint                       cost;
      longint                       span;
      int                           tries;
      span = 0;
      for (tries = 0; tries < 400 && span == 0; tries++) begin
         unit = ($urandom_range(0, 3) == 0) ? stp_pkg::UNIT_TURNS : stp_pkg::UNIT_ANGLE;
         if (unit == stp_pkg::UNIT_TURNS) begin
            code = stp_pkg::CODE_W'($urandom_range(1, 4));
         end else if ($urandom_range(0, 7) == 0) begin
            code = stp_pkg::ANGLE_MAX;
         end else begin
            code = stp_pkg::CODE_W'($urandom_range(1, ($urandom_range(0, 1) != 0) ? 360 : 40));
         end
         cycles = cycle_count(unit, code, cfg_reduction);
         cost = longint'(cycles) * PHASES_PER_CYCLE * longint'(cfg_ticks);
         if (cycles != 0 && cost <= budget) span = cost;
      end
      if (span == 0) return;
      queue_request(MODE_MOVE, 1'($urandom), unit, code);
      repeat (span) begin
         if ($urandom_range(0, 9) == 0) begin
            queue_request(MODE_MOVE, 1'($urandom), stp_pkg::UNIT_W'($urandom),
                          stp_pkg::CODE_W'($urandom));
         end
         queue_tick();
      end
      repeat ($urandom_range(0, 3)) queue_tick();
   endtask

   // Register write, only ever issued with nothing in flight
   task automatic write_register(input stp_pkg::csr_index_type idx,
                                 input logic [stp_pkg::TICKS_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == stp_pkg::CSR_REDUCTION) begin
         cfg_reduction = value[stp_pkg::REDUCTION_W-1:0];
      end else begin
         cfg_ticks = value;
      end
   endtask

   task automatic wait_drained();
      while (results_seen != queued_total) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [stp_pkg::REDUCTION_W-1:0] red;
      logic [stp_pkg::TICKS_W-1:0]     tpp;
      int                              start;
      int                              missing;

      missing = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed, at reset configuration: idle tick, refusals, zero-length moves,
      // then one cycle from 1 degree (512/360) with refused commands while busy
      queue_request(MODE_TICK, 1'b1, 8'hFF, 16'hFFFF);
      queue_request(MODE_MOVE, 1'b0, 8'd2, 16'd90);
      queue_request(MODE_MOVE, 1'b1, 8'hFF, 16'hFFFF);
      queue_request(MODE_MOVE, 1'b0, stp_pkg::UNIT_ANGLE, stp_pkg::ANGLE_MAX + 16'd1);
      queue_request(MODE_MOVE, 1'b1, stp_pkg::UNIT_ANGLE, 16'hFFFF);
      queue_request(MODE_MOVE, 1'b0, stp_pkg::UNIT_ANGLE, 16'd0);
      queue_request(MODE_MOVE, 1'b1, stp_pkg::UNIT_TURNS, 16'd0);
      queue_request(MODE_MOVE, 1'b0, stp_pkg::UNIT_ANGLE, 16'd1);
      queue_request(MODE_MOVE, 1'b0, stp_pkg::UNIT_TURNS, 16'd1);
      queue_request(MODE_MOVE, 1'b1, 8'h80, 16'd5);
      queue_request(MODE_MOVE, 1'b0, stp_pkg::UNIT_ANGLE, 16'd500);
      repeat (PHASES_PER_CYCLE * stp_pkg::TICKS_RESET) queue_tick();
      queue_tick();
      wait_drained();

      // Smallest settings: an angle that rounds down to nothing, a full reverse
      // turn by angle, then a forward turn
      write_register(stp_pkg::CSR_REDUCTION, 16'd1);
      write_register(stp_pkg::CSR_TICKS, 16'd1);
      queue_request(MODE_MOVE, 1'b0, stp_pkg::UNIT_ANGLE, stp_pkg::ANGLE_MAX - 16'd1);
      queue_request(MODE_MOVE, 1'b1, stp_pkg::UNIT_ANGLE, stp_pkg::ANGLE_MAX);
      repeat (PHASES_PER_CYCLE) queue_tick();
      queue_request(MODE_MOVE, 1'b0, stp_pkg::UNIT_TURNS, 16'd1);
      repeat (PHASES_PER_CYCLE) queue_tick();
      wait_drained();

      // Random phases, each under its own configuration, mostly complete motions
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: begin red = 12'd1;    tpp = 16'd1; end
            1: begin red = 12'hFFF;  tpp = 16'd1; end
            2: begin red = 12'd360;  tpp = 16'd2; end
            3: begin red = stp_pkg::REDUCTION_RESET; tpp = 16'd1; end
            default: begin
               red = stp_pkg::REDUCTION_W'($urandom_range(1, 64));
               tpp = stp_pkg::TICKS_W'($urandom_range(1, 5));
            end
         endcase
         write_register(stp_pkg::CSR_TICKS, tpp);
         write_register(stp_pkg::CSR_REDUCTION, 16'(red));
         start = queued_total;
         while (queued_total - start < PHASE_REQUESTS) begin
            if ($urandom_range(0, 3) != 0) begin
               queue_motion(MOTION_BUDGET);
            end else begin
               repeat ($urandom_range(1, 4)) queue_noise();
            end
         end
         wait_drained();
      end

      // Largest settings: start the longest possible move and tick a little way
      // into its first dwell of 65535 ticks, with refused commands mixed in; it is
      // still running when the run ends
      write_register(stp_pkg::CSR_REDUCTION, 16'hFFF);
      write_register(stp_pkg::CSR_TICKS, 16'hFFFF);
      queue_request(MODE_MOVE, 1'b1, stp_pkg::UNIT_TURNS, 16'hFFFF);
      for (int n = 0; n < 16; n++) begin
         if (n % 4 == 0) begin
            queue_request(MODE_MOVE, 1'($urandom), stp_pkg::UNIT_W'($urandom),
                          stp_pkg::CODE_W'($urandom));
         end
         queue_tick();
      end
      wait_drained();

      if (drive_forecast.size() != 0) begin
         $display("%0t ns: %0d expected results never arrived", $time, drive_forecast.size());
         missing = drive_forecast.size();
      end
      $display("Sequencer run: %0d requests, %0d motions started, %0d finished, %0d refused",
               requests_taken, motions_started, motions_finished, commands_refused);
      $display("Settings swept from reduction 1 / 1 tick up to reduction 4095 / 65535 ticks");
      if (fail_count == 0 && missing == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
